>>> design/bpfm_pkg.sv
package bpfm_pkg;

    localparam int FRAMES       = 16;
    localparam int PAGE_ID_BITS = 16;
    localparam int PIN_BITS     = 8;

    localparam int FRAME_BITS   = $clog2(FRAMES);
    localparam int PCNT_W       = 17;
    localparam int PORT_PAGE_W  = 16;
    localparam int PORT_FRAME_W = 4;
    localparam int STATUS_W     = 3;
    localparam int CMP_W        = (PAGE_ID_BITS + 1 > PCNT_W) ? PAGE_ID_BITS + 1 : PCNT_W;

    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    typedef enum logic [1:0] {
        ACT_FETCH = 2'd0,
        ACT_UNPIN = 2'd1,
        ACT_FLUSH = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_RANGE        = 3'd1,
        ST_ALL_PINNED   = 3'd2,
        ST_NOT_RESIDENT = 3'd3,
        ST_PINNED       = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_HIT,
        OP_LOAD,
        OP_UNPIN,
        OP_CLEAN
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    // Search record handed from cell to cell along the chain
    typedef struct packed {
        logic                    match;
        logic [FRAME_BITS-1:0]   m_idx;
        logic [FRAME_BITS-1:0]   m_rank;
        logic                    m_pinned;
        logic                    m_dirty;
        logic                    vic;
        logic [FRAME_BITS-1:0]   v_idx;
        logic [FRAME_BITS-1:0]   v_rank;
        logic                    v_valid;
        logic                    v_dirty;
        logic [PAGE_ID_BITS-1:0] v_page;
    } t_scan;

    // Update broadcast to every cell
    typedef struct packed {
        t_op                     op;
        logic [FRAME_BITS-1:0]   frame;
        logic [FRAME_BITS-1:0]   rank;
        logic [PAGE_ID_BITS-1:0] page;
        logic                    md;
    } t_cmd;

endpackage

>>> design/bpfm_cell.sv
module bpfm_cell
    import bpfm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [FRAME_BITS-1:0]   i_index,
    input  logic [PAGE_ID_BITS-1:0] i_pid,
    input  t_scan                   i_rec,
    input  t_cmd                    i_cmd,
    output t_scan                   o_rec
);

    logic [PAGE_ID_BITS-1:0] r_page;
    logic                    r_valid;
    logic [PIN_BITS-1:0]     r_pin;
    logic                    r_dirty;
    logic [FRAME_BITS-1:0]   r_rank;
    t_scan                   r_rec;
    t_scan                   n_rec;
    logic                    target;
    logic                    touch;

    assign target = (i_cmd.frame == i_index);
    assign touch  = (i_cmd.op == OP_HIT) || (i_cmd.op == OP_LOAD);

    // Keep the first valid match and the least recent unpinned frame
    always_comb begin
        n_rec = i_rec;
        if (!i_rec.match && r_valid && (r_page == i_pid)) begin
            n_rec.match    = 1'b1;
            n_rec.m_idx    = i_index;
            n_rec.m_rank   = r_rank;
            n_rec.m_pinned = (r_pin != '0);
            n_rec.m_dirty  = r_dirty;
        end
        if ((r_pin == '0) && (!i_rec.vic || (r_rank > i_rec.v_rank))) begin
            n_rec.vic     = 1'b1;
            n_rec.v_idx   = i_index;
            n_rec.v_rank  = r_rank;
            n_rec.v_valid = r_valid;
            n_rec.v_dirty = r_dirty;
            n_rec.v_page  = r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    always_ff @(posedge i_clk) begin
        if (target && (i_cmd.op == OP_LOAD)) begin
            r_page <= i_cmd.page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pin   <= '0;
            r_dirty <= 1'b0;
            r_rank  <= i_index;
        end else begin
            if (target) begin
                case (i_cmd.op)
                    OP_HIT: begin
                        if (r_pin != PIN_MAX) begin
                            r_pin <= r_pin + PIN_BITS'(1);
                        end
                    end
                    OP_LOAD: begin
                        r_valid <= 1'b1;
                        r_pin   <= PIN_BITS'(1);
                        r_dirty <= 1'b0;
                    end
                    OP_UNPIN: begin
                        r_pin   <= r_pin - PIN_BITS'(1);
                        r_dirty <= r_dirty | i_cmd.md;
                    end
                    OP_CLEAN: begin
                        r_dirty <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (touch) begin
                if (target) begin
                    r_rank <= '0;
                end else if (r_rank < i_cmd.rank) begin
                    r_rank <= r_rank + FRAME_BITS'(1);
                end
            end
        end
    end

    assign o_rec = r_rec;

endmodule

>>> design/bpfm_ctrl.sv
module bpfm_ctrl
    import bpfm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [1:0]              i_action,
    input  logic [PORT_PAGE_W-1:0]  i_page_id,
    input  logic                    i_mark_dirty,
    input  logic [PCNT_W-1:0]       i_page_count,
    input  t_scan                   i_rec,
    output logic                    o_busy,
    output logic [PAGE_ID_BITS-1:0] o_pid,
    output t_cmd                    o_cmd,
    output logic                    o_result_valid,
    output logic [STATUS_W-1:0]     o_status,
    output logic                    o_hit,
    output logic [PORT_FRAME_W-1:0] o_frame,
    output logic                    o_read_request,
    output logic                    o_writeback_request,
    output logic [PORT_PAGE_W-1:0]  o_writeback_page
);

    t_state                  r_state;
    t_state                  n_state;
    logic [FRAME_BITS-1:0]   r_cnt;
    t_action                 r_action;
    logic [PAGE_ID_BITS-1:0] r_pid;
    logic                    r_md;
    logic                    r_in_range;
    logic [PAGE_ID_BITS-1:0] in_pid;
    logic                    accept;

    t_status                 n_status;
    logic                    n_hit;
    logic [FRAME_BITS-1:0]   n_frame;
    logic                    n_rd;
    logic                    n_wb;
    logic [PAGE_ID_BITS-1:0] n_wbp;

    t_status                 r_status;
    logic                    r_hit;
    logic [FRAME_BITS-1:0]   r_frame;
    logic                    r_rd;
    logic                    r_wb;
    logic [PAGE_ID_BITS-1:0] r_wbp;
    logic                    r_strobe;

    assign in_pid = PAGE_ID_BITS'(i_page_id);
    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;
    assign o_pid  = r_pid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_APPLY);
            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + FRAME_BITS'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action   <= t_action'(i_action);
            r_pid      <= in_pid;
            r_md       <= i_mark_dirty;
            r_in_range <= (CMP_W'(in_pid) < CMP_W'(i_page_count));
        end
        if (r_state == S_APPLY) begin
            r_status <= n_status;
            r_hit    <= n_hit;
            r_frame  <= n_frame;
            r_rd     <= n_rd;
            r_wb     <= n_wb;
            r_wbp    <= n_wbp;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.op   = OP_NONE;
        o_cmd.page = r_pid;
        o_cmd.md   = r_md;
        n_status   = ST_OK;
        n_hit      = 1'b0;
        n_frame    = '0;
        n_rd       = 1'b0;
        n_wb       = 1'b0;
        n_wbp      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt == FRAME_BITS'(FRAMES - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_IDLE;
                case (r_action)
                    ACT_FETCH: begin
                        if (!r_in_range) begin
                            n_status = ST_RANGE;
                        end else if (i_rec.match) begin
                            n_hit       = 1'b1;
                            n_frame     = i_rec.m_idx;
                            o_cmd.op    = OP_HIT;
                            o_cmd.frame = i_rec.m_idx;
                            o_cmd.rank  = i_rec.m_rank;
                        end else if (i_rec.vic) begin
                            n_frame     = i_rec.v_idx;
                            n_rd        = 1'b1;
                            n_wb        = i_rec.v_valid && i_rec.v_dirty;
                            n_wbp       = n_wb ? i_rec.v_page : '0;
                            o_cmd.op    = OP_LOAD;
                            o_cmd.frame = i_rec.v_idx;
                            o_cmd.rank  = i_rec.v_rank;
                        end else begin
                            n_status = ST_ALL_PINNED;
                        end
                    end
                    ACT_UNPIN: begin
                        if (i_rec.match && i_rec.m_pinned) begin
                            n_frame     = i_rec.m_idx;
                            o_cmd.op    = OP_UNPIN;
                            o_cmd.frame = i_rec.m_idx;
                        end else begin
                            n_status = ST_NOT_RESIDENT;
                        end
                    end
                    ACT_FLUSH: begin
                        if (!i_rec.match) begin
                            n_status = ST_NOT_RESIDENT;
                        end else begin
                            n_frame = i_rec.m_idx;
                            if (i_rec.m_pinned) begin
                                n_status = ST_PINNED;
                            end else if (i_rec.m_dirty) begin
                                n_wb        = 1'b1;
                                n_wbp       = r_pid;
                                o_cmd.op    = OP_CLEAN;
                                o_cmd.frame = i_rec.m_idx;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result_valid      = r_strobe;
    assign o_status            = r_status;
    assign o_hit               = r_hit;
    assign o_frame             = PORT_FRAME_W'(r_frame);
    assign o_read_request      = r_rd;
    assign o_writeback_request = r_wb;
    assign o_writeback_page    = PORT_PAGE_W'(r_wbp);

endmodule

>>> design/buffer_pool_frame_manager.sv
// Buffer pool frame manager: page frames with pin counts and LRU replacement.
// A request is latched, searched along the frame chain, decided and applied to the cells,
// and its result is then registered onto the outputs.
// One request at a time: busy stays high from acceptance until the update is applied.
// Reset (i_rst_n low, synchronous): frames invalid, unpinned, clean, rank = frame index,
// page_count 0. Results show for one cycle on o_result_valid; the receiver cannot stall.
module buffer_pool_frame_manager
    import bpfm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_action,
    input  logic [PORT_PAGE_W-1:0]  i_page_id,
    input  logic                    i_mark_dirty,
    // page_count register write
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [PCNT_W-1:0]       i_cfg_data,
    // result
    output logic                    o_result_valid,
    output logic [STATUS_W-1:0]     o_status,
    output logic                    o_hit,
    output logic [PORT_FRAME_W-1:0] o_frame,
    output logic                    o_read_request,
    output logic                    o_writeback_request,
    output logic [PORT_PAGE_W-1:0]  o_writeback_page
);

    logic [PCNT_W-1:0]       r_page_count;
    logic [PAGE_ID_BITS-1:0] w_pid;
    t_cmd                    w_cmd;
    t_scan                   w_chain [0:FRAMES];

    // Register writes land at any time; the user must write only while idle, the block itself does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= '0;
        end else if (i_cfg_valid) begin
            r_page_count <= i_cfg_data;
        end
    end

    // Head of the chain starts with an empty record: no match, no victim.
    assign w_chain[0] = '0;

    // One cell per frame. Every cell passes the record one step right each
    // cycle, so once it has passed every cell the tail holds the first matching
    // frame and the least recent unpinned frame. The update is broadcast to all
    // cells once the tail record is complete.
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        bpfm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (FRAME_BITS'(g)),
            .i_pid   (w_pid),
            .i_rec   (w_chain[g]),
            .i_cmd   (w_cmd),
            .o_rec   (w_chain[g+1])
        );
    end

    // Sequence the request: latch, search, decide and update, report.
    bpfm_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (start),
        .i_action            (i_action),
        .i_page_id           (i_page_id),
        .i_mark_dirty        (i_mark_dirty),
        .i_page_count        (r_page_count),
        .i_rec               (w_chain[FRAMES]),
        .o_busy              (busy),
        .o_pid               (w_pid),
        .o_cmd               (w_cmd),
        .o_result_valid      (o_result_valid),
        .o_status            (o_status),
        .o_hit               (o_hit),
        .o_frame             (o_frame),
        .o_read_request      (o_read_request),
        .o_writeback_request (o_writeback_request),
        .o_writeback_page    (o_writeback_page)
    );

endmodule

>>> design/bpfm_checker.sv
module bpfm_checker
    import bpfm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    o_result_valid,
    input  logic [STATUS_W-1:0]     o_status,
    input  logic                    o_hit,
    input  logic                    o_read_request,
    input  logic                    o_writeback_request
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##18 o_result_valid)
        else $error("result strobe missing 18 cycles after request");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (!busy && !$past(o_result_valid)))
        else $error("result strobe longer than one cycle or while busy");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_hit) |-> (o_status == ST_OK && !o_read_request
                                       && !o_writeback_request))
        else $error("hit with disk request or error status");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_OK) |-> (!o_read_request && !o_writeback_request
                                                   && !o_hit))
        else $error("error status with disk request");

endmodule

bind buffer_pool_frame_manager bpfm_checker u_bpfm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_result_valid      (o_result_valid),
    .o_status            (o_status),
    .o_hit               (o_hit),
    .o_read_request      (o_read_request),
    .o_writeback_request (o_writeback_request)
);

>>> tb/tb_top.sv
module tb_top;
    import bpfm_pkg::*;

    // Spare action code that the block must ignore
    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [1:0]             action;
        logic [PORT_PAGE_W-1:0] page_id;
        logic                   mark_dirty;
    } t_page_request;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic                    hit;
        logic [PORT_FRAME_W-1:0] frame;
        logic                    read_request;
        logic                    writeback_request;
        logic [PORT_PAGE_W-1:0]  writeback_page;
    } t_frame_reply;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              i_action = '0;
    logic [PORT_PAGE_W-1:0]  i_page_id = '0;
    logic                    i_mark_dirty = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [PCNT_W-1:0]       i_cfg_data = '0;
    logic                    o_result_valid;
    logic [STATUS_W-1:0]     o_status;
    logic                    o_hit;
    logic [PORT_FRAME_W-1:0] o_frame;
    logic                    o_read_request;
    logic                    o_writeback_request;
    logic [PORT_PAGE_W-1:0]  o_writeback_page;

    buffer_pool_frame_manager dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_action            (i_action),
        .i_page_id           (i_page_id),
        .i_mark_dirty        (i_mark_dirty),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_result_valid      (o_result_valid),
        .o_status            (o_status),
        .o_hit               (o_hit),
        .o_frame             (o_frame),
        .o_read_request      (o_read_request),
        .o_writeback_request (o_writeback_request),
        .o_writeback_page    (o_writeback_page)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the frame table, the recency order and page_count
    logic [PAGE_ID_BITS-1:0] pool_page  [FRAMES];
    logic                    pool_valid [FRAMES];
    logic [PIN_BITS-1:0]     pool_pins  [FRAMES];
    logic                    pool_dirty [FRAMES];
    logic [FRAME_BITS-1:0]   pool_rank  [FRAMES];
    logic [PCNT_W-1:0]       disk_pages;

    t_page_request           requests_to_issue [$];
    t_frame_reply            frame_replies_due [$];
    logic [PORT_PAGE_W-1:0]  hot_pages [$];

    int unsigned items_queued = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_odds = 0;     // one-in-N chance per cycle of a sender idle burst; 0 = none

    // Driver-private state
    t_page_request offered;
    logic          holding = 1'b0;
    int unsigned   idle_left = 0;

    // Return the valid frame that holds this page, or -1
    function automatic int find_resident(logic [PAGE_ID_BITS-1:0] pid);
        for (int f = 0; f < FRAMES; f++)
            if (pool_valid[f] && pool_page[f] == pid)
                return f;
        return -1;
    endfunction

    // Move a frame to rank 0 and age everything that was more recent than it
    function automatic void promote(int f);
        logic [FRAME_BITS-1:0] r;
        r = pool_rank[f];
        for (int g = 0; g < FRAMES; g++)
            if (pool_rank[g] < r)
                pool_rank[g]++;
        pool_rank[f] = '0;
    endfunction

    // Apply one request to the shadow table and return the reply it must produce
    function automatic t_frame_reply serve_request(t_page_request rq);
        t_frame_reply res;
        int f;
        logic [PAGE_ID_BITS-1:0] pid;
        res = '0;
        pid = rq.page_id[PAGE_ID_BITS-1:0];
        case (rq.action)
            ACT_FETCH: begin
                if ({1'b0, pid} >= disk_pages) begin
                    res.status = ST_RANGE;
                end else begin
                    f = find_resident(pid);
                    if (f >= 0) begin
                        // hit: pin (saturating) and refresh recency
                        if (pool_pins[f] != PIN_MAX)
                            pool_pins[f]++;
                        promote(f);
                        res.hit = 1'b1;
                        res.frame = PORT_FRAME_W'(f);
                    end else begin
                        // miss: least recent unpinned frame is the victim
                        f = -1;
                        for (int g = 0; g < FRAMES; g++)
                            if (pool_pins[g] == 0 && (f < 0 || pool_rank[g] > pool_rank[f]))
                                f = g;
                        if (f < 0) begin
                            res.status = ST_ALL_PINNED;
                        end else begin
                            if (pool_valid[f] && pool_dirty[f]) begin
                                res.writeback_request = 1'b1;
                                res.writeback_page = PORT_PAGE_W'(pool_page[f]);
                            end
                            res.read_request = 1'b1;
                            pool_page[f] = pid;
                            pool_valid[f] = 1'b1;
                            pool_dirty[f] = 1'b0;
                            pool_pins[f] = PIN_BITS'(1);
                            promote(f);
                            res.frame = PORT_FRAME_W'(f);
                        end
                    end
                end
            end
            ACT_UNPIN: begin
                f = find_resident(pid);
                if (f < 0 || pool_pins[f] == 0) begin
                    res.status = ST_NOT_RESIDENT;
                end else begin
                    if (rq.mark_dirty)
                        pool_dirty[f] = 1'b1;
                    pool_pins[f]--;
                    res.frame = PORT_FRAME_W'(f);
                end
            end
            ACT_FLUSH: begin
                f = find_resident(pid);
                if (f < 0) begin
                    res.status = ST_NOT_RESIDENT;
                end else begin
                    res.frame = PORT_FRAME_W'(f);
                    if (pool_pins[f] > 0) begin
                        res.status = ST_PINNED;
                    end else if (pool_dirty[f]) begin
                        res.writeback_request = 1'b1;
                        res.writeback_page = PORT_PAGE_W'(pid);
                        pool_dirty[f] = 1'b0;
                    end
                end
            end
            default: begin
                // reserved action: no state change, all-zero reply
            end
        endcase
        return res;
    endfunction

    // Driver: hold each request on the port until it is taken, with random idle bursts
    always @(posedge i_clk) begin : drive_requests
        logic quiet;
        quiet = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
            holding = 1'b0;
            idle_left = 0;
        end else begin
            // request taken at this edge: predict its reply now
            if (start && !busy) begin
                frame_replies_due.insert(frame_replies_due.size(), serve_request(offered));
                holding = 1'b0;
            end
            if (!holding && requests_to_issue.size() > 0) begin
                offered = requests_to_issue.pop_front();
                holding = 1'b1;
            end
            // bursts run independent of busy, so they land on any phase of the search
            if (idle_left > 0) begin
                idle_left--;
                quiet = 1'b1;
            end else if (gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
                idle_left = $urandom_range(0, 6);
                quiet = 1'b1;
            end
            start <= holding && !quiet;
            i_action <= offered.action;
            i_page_id <= offered.page_id;
            i_mark_dirty <= offered.mark_dirty;
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: each strobe retires the oldest reply still due
    always @(posedge i_clk) begin : watch_replies
        t_frame_reply want;
        if (i_rst_n && o_result_valid) begin
            results_seen++;
            if (frame_replies_due.size() == 0) begin
                $error("result strobe with no request outstanding");
                mismatches++;
            end else begin
                want = frame_replies_due.pop_front();
                check_field("status", want.status, o_status);
                check_field("hit", want.hit, o_hit);
                check_field("frame", want.frame, o_frame);
                check_field("read_request", want.read_request, o_read_request);
                check_field("writeback_request", want.writeback_request, o_writeback_request);
                check_field("writeback_page", want.writeback_page, o_writeback_page);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[buffer_pool_frame_manager] ERROR");
            $finish;
        end
    end

    task automatic queue_request(logic [1:0] act, logic [PORT_PAGE_W-1:0] pid, logic md);
        t_page_request rq;
        rq.action = act;
        rq.page_id = pid;
        rq.mark_dirty = md;
        requests_to_issue.insert(requests_to_issue.size(), rq);
        items_queued++;
    endtask

    // Hold until every reply is in and the block has gone idle
    task automatic drain();
        wait (results_seen == items_queued);
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Write page_count; only called with the block idle
    task automatic write_page_count(logic [PCNT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        disk_pages = value;
    endtask

    // Build a working set a bit larger than the frame count to force evictions
    task automatic pick_hot_pages(int unsigned count, int unsigned lo, int unsigned hi);
        hot_pages.delete();
        for (int k = 0; k < count; k++)
            hot_pages.insert(hot_pages.size(), PORT_PAGE_W'($urandom_range(lo, hi)));
    endtask

    // Mostly fetch/unpin/flush traffic on the working set, the rest raw noise
    task automatic run_random(int unsigned n, int unsigned odds);
        logic [1:0] act;
        int unsigned roll;
        gap_odds = odds;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 8) begin
                queue_request(2'($urandom_range(0, 3)), PORT_PAGE_W'($urandom),
                              1'($urandom_range(0, 1)));
            end else begin
                roll = $urandom_range(0, 99);
                act = (roll < 45) ? ACT_FETCH : (roll < 85) ? ACT_UNPIN : ACT_FLUSH;
                queue_request(act, hot_pages[$urandom_range(0, hot_pages.size() - 1)],
                              1'($urandom_range(0, 1)));
            end
        end
        drain();
    endtask

    initial begin
        int unsigned span;
        for (int f = 0; f < FRAMES; f++) begin
            pool_page[f] = '0;
            pool_valid[f] = 1'b0;
            pool_pins[f] = '0;
            pool_dirty[f] = 1'b0;
            pool_rank[f] = FRAME_BITS'(f);
        end
        disk_pages = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // page_count is 0 out of reset: every fetch is out of range, nothing resident
        gap_odds = 4;
        queue_request(ACT_FETCH, 16'h0000, 1'b0);
        queue_request(ACT_UNPIN, 16'h0000, 1'b1);
        queue_request(ACT_FLUSH, 16'h0000, 1'b0);
        queue_request(ACT_RESERVED, 16'hFFFF, 1'b1);
        drain();

        write_page_count({PCNT_W{1'b1}});
        queue_request(ACT_FETCH, 16'hFFFF, 1'b0);   // miss into an empty frame
        queue_request(ACT_FETCH, 16'h0000, 1'b0);
        queue_request(ACT_FETCH, 16'hFFFF, 1'b0);   // hit, second pin
        queue_request(ACT_UNPIN, 16'hFFFF, 1'b1);
        queue_request(ACT_FLUSH, 16'hFFFF, 1'b0);   // still pinned: refused
        queue_request(ACT_UNPIN, 16'hFFFF, 1'b0);
        queue_request(ACT_UNPIN, 16'hFFFF, 1'b1);   // pin count zero: not resident, dirty bit unchanged
        queue_request(ACT_UNPIN, 16'h0000, 1'b0);
        queue_request(ACT_FLUSH, 16'h0000, 1'b0);   // clean unpinned: no writeback
        queue_request(ACT_FLUSH, 16'hFFFF, 1'b0);   // dirty: writeback
        queue_request(ACT_FLUSH, 16'hFFFF, 1'b0);
        queue_request(ACT_FLUSH, 16'h1234, 1'b0);   // never fetched
        queue_request(ACT_FETCH, 16'h0000, 1'b0);
        queue_request(ACT_UNPIN, 16'h0000, 1'b1);
        drain();

        // Pin every frame, overflow, then release; the dirty page gets evicted with writeback
        gap_odds = 3;
        for (int p = 1; p <= FRAMES; p++)
            queue_request(ACT_FETCH, PORT_PAGE_W'(p), 1'b0);
        queue_request(ACT_FETCH, PORT_PAGE_W'(FRAMES + 1), 1'b0);
        queue_request(ACT_FLUSH, 16'h0005, 1'b0);
        for (int p = 1; p <= FRAMES; p++)
            queue_request(ACT_UNPIN, PORT_PAGE_W'(p), 1'(p % 2));
        drain();

        // Drive one pin count into saturation, then unpin it down to zero and once more
        gap_odds = 9;
        for (int k = 0; k < (1 << PIN_BITS) + 1; k++)
            queue_request(ACT_FETCH, 16'h5A5A, 1'b0);
        for (int k = 0; k < (1 << PIN_BITS); k++)
            queue_request(ACT_UNPIN, 16'h5A5A, 1'($urandom_range(0, 1)));
        drain();

        // Single-page disk: only page 0 can be fetched
        write_page_count(17'd1);
        hot_pages.delete();
        hot_pages.insert(hot_pages.size(), 16'h0000);
        hot_pages.insert(hot_pages.size(), 16'h0001);
        hot_pages.insert(hot_pages.size(), 16'h0002);
        hot_pages.insert(hot_pages.size(), 16'hFFFF);
        run_random(20, 5);

        // Small disk; working set straddles the range limit; no idling here
        write_page_count(17'd40);
        pick_hot_pages(24, 0, 47);
        run_random(35, 0);

        // Exactly the full id space
        write_page_count(17'd65536);
        pick_hot_pages(24, 0, 65535);
        run_random(35, 6);

        span = $urandom_range(100, 65535);
        write_page_count(PCNT_W'(span));
        pick_hot_pages(20, 0, (span + 3 > 65535) ? 65535 : span + 3);
        run_random(25, 3);

        // Top id falls just out of range
        write_page_count(17'd65535);
        pick_hot_pages(19, 0, 65535);
        hot_pages.insert(hot_pages.size(), 16'hFFFF);
        run_random(15, 8);

        // Tail: back-to-back requests with no sender idling
        write_page_count({PCNT_W{1'b1}});
        pick_hot_pages(20, 0, 65535);
        run_random(30, 0);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (frame_replies_due.size() != 0) begin
            $error("%0d replies never arrived", frame_replies_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[buffer_pool_frame_manager] OK");
        else
            $display("[buffer_pool_frame_manager] ERROR");
        $finish;
    end

endmodule

>>> buffer_pool_frame_manager.f
design/bpfm_pkg.sv
design/bpfm_cell.sv
design/bpfm_ctrl.sv
design/buffer_pool_frame_manager.sv
design/bpfm_checker.sv
tb/tb_top.sv
